FILE: design/abam_pkg.sv
// shared types and constants of the arena bump allocator
package abam_pkg;

  localparam int MARK_DEPTH = 1024;
  localparam int MARK_AW    = $clog2(MARK_DEPTH);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_MARK    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_MARKS_FULL = 2'd2;
  localparam logic [1:0] ST_UNKNOWN    = 2'd3;

  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_SIZE = 2'd1;

  typedef struct packed {
    logic exec;
    logic srch_start;
    logic rd;
    logic cmp;
    logic fail;
  } cmd_t;

  typedef struct packed {
    logic out_room;
    logic idx_end;
    logic hit;
  } stat_t;

endpackage

FILE: design/abam_ctrl.sv
// controller state machine: item acceptance and mark stack search sequencing
module abam_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  abam_pkg::stat_t      stat,
  output abam_pkg::cmd_t       cmd
);
  import abam_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CMP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && stat.out_room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_RELEASE) begin
            cmd.srch_start = 1'b1;
            state_nxt      = S_READ;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_READ: begin
        if (stat.idx_end) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (stat.hit) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/abam_dp.sv
// datapath: arena registers, fill offset, mark stack memory and result word register
module abam_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  abam_pkg::cmd_t       cmd,
  output abam_pkg::stat_t      stat,
  input  logic [1:0]           in_kind,
  input  logic [30:0]          in_alloc_bytes,
  input  logic [31:0]          in_release_address,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_block_address,
  output logic [1:0]           out_status,
  output logic [30:0]          out_used_bytes,
  output logic [30:0]          out_free_bytes
);
  import abam_pkg::*;

  logic [31:0]        base_r;
  logic [30:0]        size_r;
  logic [30:0]        fill_r, fill_nxt;
  logic [MARK_AW-1:0] count_r, count_nxt;
  logic [MARK_AW-1:0] idx_r, idx_nxt;
  logic [31:0]        rel_r, rel_nxt;
  logic [30:0]        rd_data_r;
  logic [30:0]        mark_mem [MARK_DEPTH];
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        addr_r;
  logic [1:0]         st_r;
  logic [30:0]        used_r, free_r;

  logic [31:0] addr_now, sum_ext, cand_addr, free_ext, o_addr;
  logic [30:0] o_free;
  logic [1:0]  o_st;
  logic        alloc_full, mark_full, hit, ld, mem_we;

  always_comb begin
    addr_now   = base_r + {1'b0, fill_r};
    sum_ext    = {1'b0, fill_r} + {1'b0, in_alloc_bytes};
    alloc_full = sum_ext > {1'b0, size_r};
    mark_full  = count_r == MARK_AW'(MARK_DEPTH - 1);
    cand_addr  = base_r + {1'b0, rd_data_r};
    hit        = cand_addr == rel_r;

    fill_nxt  = fill_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rel_nxt   = rel_r;
    ld        = 1'b0;
    mem_we    = 1'b0;
    o_addr    = '0;
    o_st      = ST_OK;

    if (cmd.exec) begin
      ld = 1'b1;
      case (in_kind)
        KIND_ALLOC: begin
          if (alloc_full) begin
            o_st = ST_FULL;
          end else begin
            o_addr   = addr_now;
            fill_nxt = sum_ext[30:0];
          end
        end
        KIND_MARK: begin
          if (mark_full) begin
            o_st = ST_MARKS_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
            o_addr    = addr_now;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.srch_start) begin
      rel_nxt = in_release_address;
      idx_nxt = '0;
    end
    if (cmd.cmp) begin
      if (hit) begin
        ld        = 1'b1;
        o_addr    = cand_addr;
        fill_nxt  = rd_data_r;
        count_nxt = idx_r;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (cmd.fail) begin
      ld   = 1'b1;
      o_st = ST_UNKNOWN;
    end

    // free space saturates at zero when the arena shrank below the fill point
    free_ext = {1'b0, size_r} - {1'b0, fill_nxt};
    o_free   = free_ext[31] ? '0 : free_ext[30:0];

    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign stat.out_room = !out_valid_r || out_ready;
  assign stat.idx_end  = idx_r == count_r;
  assign stat.hit      = hit;

  assign out_valid         = out_valid_r;
  assign out_block_address = addr_r;
  assign out_status        = st_r;
  assign out_used_bytes    = used_r;
  assign out_free_bytes    = free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      size_r      <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_BASE) begin
        base_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_SIZE) begin
        size_r <= cfg_data[30:0];
      end
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rel_r <= rel_nxt;
    if (ld) begin
      addr_r <= o_addr;
      st_r   <= o_st;
      used_r <= fill_nxt;
      free_r <= o_free;
    end
  end

  // mark stack: one write port at the top, one registered read port for the search
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[count_r] <= fill_r;
    end
    if (cmd.rd) begin
      rd_data_r <= mark_mem[idx_r];
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("search index beyond mark count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(ld && out_valid_r && !out_ready))
    else $error("result word overwritten while waiting");

  a_mark_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && in_kind == KIND_MARK && !mark_full) |=>
      count_r == $past(count_r) + 1'b1)
    else $error("mark push did not advance count");

endmodule

FILE: design/arena_bump_allocator_with_marks.sv
// top level of the arena bump allocator with mark stack
//
// input channel (in_): one word per item, kind selects allocate, push mark or
// release to mark; the result channel (out_) returns one word per item with
// block address, status, used and free bytes.
// cfg_ writes base address (index 0) or arena size (index 1); the user does
// so while idle, unenforced; other indexes are ignored; cfg_ready always high.
// allocate, mark and unused kinds give their result in the cycle after
// acceptance; a release searches the mark stack from position 0 upward until
// a mark matches or all marks held are read, which gives status unknown.
// the search alternates read and compare states, using the registered read
// port of the mark stack memory.
// throughput: one allocate or mark item per cycle while out_ready is high;
// a release holds in_ready low until its result is loaded.
// the result register lets a new item in the cycle the waiting word is taken;
// while the receiver stalls, in_ready stays low.
// reset clears arena registers, fill offset and mark count; the mark stack
// needs no clearing as only written entries are ever read.
module arena_bump_allocator_with_marks (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [30:0] in_alloc_bytes,
  input  logic [31:0] in_release_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_block_address,
  output logic [1:0]  out_status,
  output logic [30:0] out_used_bytes,
  output logic [30:0] out_free_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import abam_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  abam_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  abam_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_alloc_bytes     (in_alloc_bytes),
    .in_release_address (in_release_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_block_address  (out_block_address),
    .out_status         (out_status),
    .out_used_bytes     (out_used_bytes),
    .out_free_bytes     (out_free_bytes)
  );

endmodule
